// ----- hw/rtl/chkl_pkg.sv -----
// Shared types and constants for the chained hash key lookup block.
// Used by the top level, its port checker and the bench; depends on nothing else.
package chkl_pkg;

  localparam int KEY_WORDS = 5;
  localparam int WORD_W    = 32;
  localparam int KEY_W     = KEY_WORDS * WORD_W;
  localparam int HANDLE_W  = 16;
  localparam int CFG_W     = 11;
  localparam int STATUS_W  = 2;

  // remainder unit: quotient bits retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = WORD_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

endpackage

// ----- hw/rtl/chained_hash_key_lookup.sv -----
// Chained hash key lookup: insert and look up 160-bit keys in a bucket-head table
// over an entry pool. Depends on chkl_pkg.
//
// One transaction at a time. A transaction steps through accepting the request, the bucket
// remainder (an iterative subtract-compare unit retiring 4 bits a cycle), the bucket-head
// memory read, on a lookup the chain walk (one entry per cycle through the pool memory
// read port), and loading the output register. in_ready is low while a transaction is in
// progress; the result register lets the next transaction be accepted before the previous
// result is taken. After reset a clearing pass over all MAX_BUCKETS bucket heads empties
// them, with in_ready low; cfg writes are taken at all times. bucket_count 0 acts as 1,
// values above MAX_BUCKETS act as MAX_BUCKETS. Inserts beyond POOL_ENTRIES are refused.
module chained_hash_key_lookup
  import chkl_pkg::*;
#(
  parameter int MAX_BUCKETS  = 1024,
  parameter int POOL_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [WORD_W-1:0]   in_key_word0,
  input  logic [WORD_W-1:0]   in_key_word1,
  input  logic [WORD_W-1:0]   in_key_word2,
  input  logic [WORD_W-1:0]   in_key_word3,
  input  logic [WORD_W-1:0]   in_key_word4,
  input  logic [HANDLE_W-1:0] in_entry_handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_bucket_count
);

  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int PTR_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int USED_W = $clog2(POOL_ENTRIES + 1);
  localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
  localparam int N_W    = (NB_W > CFG_W) ? NB_W : CFG_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_HRD   = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  typedef struct packed {
    logic             vld;
    logic [PTR_W-1:0] ptr;
  } head_t;

  typedef struct packed {
    key_t                key;
    logic [HANDLE_W-1:0] handle;
    head_t               link;
  } entry_t;

  head_t  head_mem [MAX_BUCKETS];
  entry_t pool_mem [POOL_ENTRIES];

  logic [2:0]           state_r, state_nxt;
  logic [BKT_W-1:0]     clr_r;
  logic [N_W-1:0]       cfg_r;
  logic [N_W-1:0]       n_r;
  logic [N_W-1:0]       n_eff;
  logic [N_W-1:0]       rem_r, rem_nxt;
  logic [WORD_W-1:0]    fold_r, fold_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 func_r;
  key_t                 key_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [BKT_W-1:0]     bkt_r;
  logic [USED_W-1:0]    used_r;
  logic                 pool_full;
  logic [STATUS_W-1:0]  st_r;
  logic [HANDLE_W-1:0]  hdl_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [HANDLE_W-1:0]  out_handle_r;

  head_t                head_q_r;
  entry_t               pool_q_r;
  logic                 head_we;
  logic [BKT_W-1:0]     head_waddr;
  head_t                head_wdata;
  logic                 pool_we;
  logic                 pool_re;
  logic [PTR_W-1:0]     pool_raddr;
  logic                 key_hit;
  logic                 in_acc;
  logic                 out_load;

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;

  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign pool_full = (used_r == USED_W'(POOL_ENTRIES));
  assign key_hit   = (pool_q_r.key == key_r);

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = N_W'(1);
    end else if (cfg_r > N_W'(MAX_BUCKETS)) begin
      n_eff = N_W'(MAX_BUCKETS);
    end else begin
      n_eff = cfg_r;
    end
  end

  // restoring remainder, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [N_W:0] t;
    rem_nxt  = rem_r;
    fold_nxt = fold_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t        = {rem_nxt, fold_nxt[WORD_W-1]};
      fold_nxt = fold_nxt << 1;
      if (t >= {1'b0, n_r}) begin
        t = t - {1'b0, n_r};
      end
      rem_nxt = t[N_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == BKT_W'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_HRD;
        end
      end
      S_HRD: state_nxt = S_HEAD;
      S_HEAD: begin
        if (func_r == FUNC_LOOKUP && head_q_r.vld) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CMP: begin
        if (key_hit || !pool_q_r.link.vld) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cfg_r       <= N_W'(MAX_BUCKETS);
      used_r      <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= N_W'(cfg_bucket_count);
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end else begin
        div_cnt_r <= '0;
      end
      if (pool_we) begin
        used_r <= used_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_func;
      key_r    <= {in_key_word4, in_key_word3, in_key_word2, in_key_word1, in_key_word0};
      handle_r <= in_entry_handle;
      fold_r   <= in_key_word0 ^ in_key_word1 ^ in_key_word2 ^ in_key_word3 ^ in_key_word4;
      rem_r    <= '0;
      n_r      <= n_eff;
    end else if (state_r == S_DIV) begin
      fold_r <= fold_nxt;
      rem_r  <= rem_nxt;
    end
    if (state_r == S_HRD) begin
      bkt_r <= BKT_W'(rem_r);
    end
    if (state_r == S_HEAD) begin
      hdl_r <= '0;
      if (func_r == FUNC_INSERT) begin
        st_r <= pool_full ? STATUS_POOL_FULL : STATUS_INSERTED;
      end else begin
        st_r <= STATUS_NOT_FOUND;
      end
    end
    if (state_r == S_CMP && key_hit) begin
      st_r  <= STATUS_FOUND;
      hdl_r <= pool_q_r.handle;
    end
    if (out_load) begin
      out_status_r <= st_r;
      out_handle_r <= hdl_r;
    end
  end

  assign head_we    = (state_r == S_CLEAR) || pool_we;
  assign head_waddr = (state_r == S_CLEAR) ? clr_r : bkt_r;
  assign head_wdata = (state_r == S_CLEAR) ? head_t'('0) : head_t'({1'b1, PTR_W'(used_r)});

  assign pool_we    = (state_r == S_HEAD) && (func_r == FUNC_INSERT) && !pool_full;
  assign pool_re    = ((state_r == S_HEAD) && (func_r == FUNC_LOOKUP) && head_q_r.vld) ||
                      ((state_r == S_CMP) && !key_hit && pool_q_r.link.vld);
  assign pool_raddr = (state_r == S_HEAD) ? head_q_r.ptr : pool_q_r.link.ptr;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (state_r == S_HRD) begin
      head_q_r <= head_mem[BKT_W'(rem_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[PTR_W'(used_r)] <= '{key: key_r, handle: handle_r, link: head_q_r};
    end
    if (pool_re) begin
      pool_q_r <= pool_mem[pool_raddr];
    end
  end

endmodule

// ----- hw/rtl/chkl_sva.sv -----
// Port-level checker for chained_hash_key_lookup, attached by bind.
// Depends on chkl_pkg.
module chkl_sva
  import chkl_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [HANDLE_W-1:0] out_result_handle
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction accepted while one is in progress");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_FOUND) |-> out_result_handle == '0)
    else $error("nonzero handle without a hit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_result_handle))
    else $error("result changed while stalled");

endmodule

bind chained_hash_key_lookup chkl_sva u_chkl_sva (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_result_handle(out_result_handle)
);

// ----- test/tb_chained_hash_key_lookup.sv -----
`timescale 1ns / 100ps
// Self-checking bench for chained_hash_key_lookup: inserts and lookups of 160-bit keys,
// predicted by a local hash table model and checked across several bucket counts.
// Depends on chkl_pkg and the chained_hash_key_lookup RTL.
module tb_chained_hash_key_lookup;
  import chkl_pkg::*;

  localparam int MAX_BUCKETS  = 1024;
  localparam int POOL_ENTRIES = 256;

  typedef struct {
    logic                func;
    key_t                key;
    logic [HANDLE_W-1:0] handle;
    bit                  hold;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = FUNC_INSERT;
  logic [WORD_W-1:0]   in_key_word0 = '0;
  logic [WORD_W-1:0]   in_key_word1 = '0;
  logic [WORD_W-1:0]   in_key_word2 = '0;
  logic [WORD_W-1:0]   in_key_word3 = '0;
  logic [WORD_W-1:0]   in_key_word4 = '0;
  logic [HANDLE_W-1:0] in_entry_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_result_handle;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_bucket_count = '0;

  // hash table model
  bit                  head_used [MAX_BUCKETS];
  int unsigned         head_entry [MAX_BUCKETS];
  key_t                entry_key [POOL_ENTRIES];
  logic [HANDLE_W-1:0] entry_handle [POOL_ENTRIES];
  bit                  link_used [POOL_ENTRIES];
  int unsigned         link_entry [POOL_ENTRIES];
  int unsigned         entries_taken = 0;
  logic [CFG_W-1:0]    model_bucket_count = CFG_W'(MAX_BUCKETS);

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  key_t     known_keys[$];
  request_t on_bus;
  int       send_idle_pct = 15;
  int       recv_idle_pct = 70;
  int       mismatches = 0;

  chained_hash_key_lookup #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_ENTRIES(POOL_ENTRIES)
  ) dut (.*);

  always #4 clk = ~clk;

  initial begin
    #25_000_000;
    $display("chained_hash_key_lookup: mismatch");
    $finish;
  end

  function automatic logic [WORD_W-1:0] fold_key(key_t k);
    return k[0] ^ k[1] ^ k[2] ^ k[3] ^ k[4];
  endfunction

  function automatic answer_t apply_to_table(request_t req);
    answer_t     ans;
    int unsigned buckets;
    int unsigned b;
    int unsigned e;
    bit          live;
    buckets = (model_bucket_count == 0) ? 1 : model_bucket_count;
    if (buckets > MAX_BUCKETS) buckets = MAX_BUCKETS;
    b = fold_key(req.key) % buckets;
    ans.status = STATUS_NOT_FOUND;
    ans.handle = '0;
    if (req.func == FUNC_INSERT) begin
      if (entries_taken >= POOL_ENTRIES) begin
        ans.status = STATUS_POOL_FULL;
      end else begin
        e = entries_taken;
        entry_key[e] = req.key;
        entry_handle[e] = req.handle;
        link_used[e] = head_used[b];
        link_entry[e] = head_entry[b];
        head_used[b] = 1'b1;
        head_entry[b] = e;
        entries_taken++;
        ans.status = STATUS_INSERTED;
      end
    end else begin
      live = head_used[b];
      e = head_entry[b];
      while (live) begin
        if (entry_key[e] == req.key) begin
          ans.status = STATUS_FOUND;
          ans.handle = entry_handle[e];
          live = 1'b0;
        end else begin
          live = link_used[e];
          e = link_entry[e];
        end
      end
    end
    return ans;
  endfunction

  function automatic void report_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] ERROR %s", $time, msg);
  endfunction

  function automatic key_t make_key(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                    logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3,
                                    logic [WORD_W-1:0] w4);
    return {w4, w3, w2, w1, w0};
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    else if (pick == 1) return '1;
    else return $urandom;
  endfunction

  function automatic key_t rand_key();
    key_t k;
    for (int i = 0; i < KEY_WORDS; i++) k[i] = rand_word();
    return k;
  endfunction

  function automatic key_t known_key();
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  // new key with the fold of a stored one: same bucket under any count
  function automatic key_t colliding_key();
    key_t k;
    k = rand_key();
    k[4] = fold_key(known_key()) ^ k[0] ^ k[1] ^ k[2] ^ k[3];
    return k;
  endfunction

  function automatic void queue_request(logic func, key_t key, logic [HANDLE_W-1:0] handle);
    request_t req;
    req.func = func;
    req.key = key;
    req.handle = handle;
    req.hold = ($urandom_range(99) == 0);
    pending_requests.push_back(req);
    if (func == FUNC_INSERT) known_keys.push_back(key);
  endfunction

  task automatic queue_random(int count);
    key_t k;
    int   pick;
    int   word_sel;
    int   bit_sel;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        pick = $urandom_range(99);
        if (pick < 15) k = known_key();
        else if (pick < 35) k = colliding_key();
        else k = rand_key();
        queue_request(FUNC_INSERT, k, HANDLE_W'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          k = known_key();
        end else if (pick < 80) begin
          k = known_key();
          word_sel = $urandom_range(KEY_WORDS - 1);
          bit_sel = $urandom_range(WORD_W - 1);
          k[word_sel][bit_sel] = ~k[word_sel][bit_sel];
        end else if (pick < 90) begin
          k = colliding_key();
        end else begin
          k = rand_key();
        end
        queue_request(FUNC_LOOKUP, k, HANDLE_W'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_bucket_count <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_bucket_count = value;
  endtask

  // driver: predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_answers.push_back(apply_to_table(on_bus));
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_requests[0].hold && expected_answers.size() != 0)) begin
          on_bus = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_func <= on_bus.func;
          in_key_word0 <= on_bus.key[0];
          in_key_word1 <= on_bus.key[1];
          in_key_word2 <= on_bus.key[2];
          in_key_word3 <= on_bus.key[3];
          in_key_word4 <= on_bus.key[4];
          in_entry_handle <= on_bus.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report_error($sformatf("unexpected result: status %0d handle %h",
                                 out_status, out_result_handle));
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status)
            report_error($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_result_handle !== want.handle)
            report_error($sformatf("handle %h, expected %h", out_result_handle, want.handle));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(FUNC_LOOKUP, '0, 16'hFFFF);
    queue_request(FUNC_INSERT, '0, 16'h0000);
    queue_request(FUNC_INSERT, '1, 16'hFFFF);
    queue_request(FUNC_LOOKUP, '0, 16'h0000);
    queue_request(FUNC_LOOKUP, '1, 16'h0000);
    queue_request(FUNC_INSERT, make_key(1, 2, 3, 4, 5), 16'h1234);
    queue_request(FUNC_INSERT, make_key(5, 4, 3, 2, 1), 16'h5678);
    queue_request(FUNC_LOOKUP, make_key(1, 2, 3, 4, 5), 16'h0000);
    queue_request(FUNC_LOOKUP, make_key(5, 4, 3, 2, 1), 16'h0000);
    queue_request(FUNC_LOOKUP, make_key(3, 2, 1, 5, 4), 16'h0000);
    queue_request(FUNC_INSERT, make_key(1, 2, 3, 4, 5), 16'hAAAA);
    queue_request(FUNC_LOOKUP, make_key(1, 2, 3, 4, 5), 16'h5555);
    queue_request(FUNC_LOOKUP, make_key(32'hFFFF_FFFE, '1, '1, '1, '1), 16'h0000);
    queue_request(FUNC_INSERT, make_key(32'h3FF, 0, 0, 0, 0), 16'h8001);
    queue_request(FUNC_INSERT, make_key(32'hFFFF_FFFF, 0, 0, 0, 0), 16'h0001);
    queue_request(FUNC_LOOKUP, make_key(32'h3FF, 0, 0, 0, 0), 16'h0000);
    queue_request(FUNC_LOOKUP, make_key(32'hFFFF_FFFF, 0, 0, 0, 0), 16'h0000);
    queue_request(FUNC_LOOKUP, make_key(32'h7FF, 0, 0, 0, 0), 16'h0000);
    queue_random(332);
    wait_idle();

    write_bucket_count(0);
    queue_random(250);
    wait_idle();

    send_idle_pct = 70;
    recv_idle_pct = 15;
    write_bucket_count('1);
    queue_random(350);
    wait_idle();

    write_bucket_count(1);
    queue_random(250);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_bucket_count(CFG_W'(MAX_BUCKETS + 1));
    queue_random(300);
    wait_idle();

    write_bucket_count(CFG_W'($urandom_range(2, MAX_BUCKETS - 1)));
    queue_random(300);
    wait_idle();

    repeat (300) @(posedge clk);
    if (expected_answers.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_answers.size()));
    if (mismatches == 0) begin
      $display("chained_hash_key_lookup: match");
    end else begin
      $display("chained_hash_key_lookup: mismatch");
    end
    $finish;
  end

endmodule
